/* src/dlst_pkg.sv */
// ----------------------------------------------------------------------------
// dlst_pkg: shared types and constants for the decaying light slot table
// Action codes, pick kinds, the slot entry layout and tick decay constants.
// ----------------------------------------------------------------------------
package dlst_pkg;

  // default table depth
  localparam int SLOTS_DEF = 32;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_EMIT  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  localparam logic [1:0] PICK_KEY     = 2'd0;
  localparam logic [1:0] PICK_EXPIRED = 2'd1;
  localparam logic [1:0] PICK_FORCED  = 2'd2;

  typedef struct packed {
    logic [15:0] key;
    logic [30:0] expiry;
    logic [23:0] radius;
    logic [15:0] decay;
  } entry_t;

  // drop = floor(p * 256 / 1000) with p = frame_ms * decay.
  // p >= DROP_LIMIT gives drop >= 2^24, which always empties a slot.
  // Below it, x = p * 32 < 2^31 and floor(x / 125) = (x * RECIP) >> RECIP_SHIFT.
  localparam logic [31:0] DROP_LIMIT  = 32'd65536000;
  localparam logic [31:0] RECIP       = 32'd2199023256;
  localparam int          RECIP_SHIFT = 38;

endpackage

/* src/decaying_light_slot_table.sv */
// ----------------------------------------------------------------------------
// decaying_light_slot_table: keyed light slot allocator with expiry and decay
// Allocate, tick, emit and clear over a table of SLOTS slots in one memory.
// ----------------------------------------------------------------------------
// Allocate: scans every slot, then writes the pick and strobes its single result.
// Tick: per slot, read, multiply, multiply again and write back, around the one shared multiplier.
// Emit: reads every slot and strobes one result per cycle, SLOTS in all.
// Clear: wipes the table at transfer. busy stays high while an item is worked; results are
// strobed one cycle each and the receiver cannot stall them.
// Reset (rst, synchronous): per-slot valid flops clear, table reads as zero.
module decaying_light_slot_table #(
  parameter int SLOTS = dlst_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [15:0] light_key,
  input  logic [30:0] now_time,
  input  logic [15:0] frame_ms,
  input  logic [23:0] new_radius,
  input  logic [15:0] new_decay,
  input  logic [30:0] new_expiry,
  output logic        result_strobe,
  output logic [7:0]  slot_index,
  output logic [23:0] slot_radius,
  output logic [1:0]  pick_kind,
  output logic        slot_live,
  output logic        last_item
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,   // alloc/emit: one read per cycle
    S_TAIL,   // last read data evaluated
    S_AWRITE, // alloc: load picked slot, strobe result
    S_TRD,    // tick: read slot
    S_TMUL1,  // tick: p = frame_ms * decay
    S_TMUL2,  // tick: drop = (p * 32) * RECIP >> RECIP_SHIFT
    S_TWR     // tick: write back radius
  } state_t;

  state_t state;

  // transfer latched at accept
  dlst_pkg::action_t act;
  logic [15:0] key_q;
  logic [30:0] now_q;
  logic [15:0] fms_q;
  logic [23:0] nrad_q;
  logic [15:0] ndec_q;
  logic [30:0] nexp_q;

  logic [IW-1:0] idx;
  logic          eval_on;   // read data of rd_idx is fresh this cycle

  // allocate search results
  logic          found_key;
  logic [IW-1:0] key_idx;
  logic          found_exp;
  logic [IW-1:0] exp_idx;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [63:0] prod;
  logic        big;

  // slot memory and valid flops
  dlst_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  dlst_pkg::entry_t rdata;
  logic             rd_valid;
  logic [IW-1:0]    rd_idx;

  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  dlst_pkg::entry_t wr_data;
  logic             clr_all;

  dlst_pkg::entry_t entry;
  logic             key_hit;
  logic             expired;
  logic [23:0]      drop;
  logic [23:0]      rad_new;
  logic [IW-1:0]    pick;
  logic [1:0]       kind;
  logic             accept;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // never-written or cleared slots read as zero
  assign entry   = rd_valid ? rdata : '0;
  assign key_hit = (key_q != 16'd0) && (entry.key == key_q);
  assign expired = (entry.expiry < now_q);

  assign drop = prod[dlst_pkg::RECIP_SHIFT +: 24];

  always_comb begin
    if (expired || big || (drop >= entry.radius)) begin
      rad_new = 24'd0;
    end else begin
      rad_new = entry.radius - drop;
    end
  end

  always_comb begin
    if (found_key) begin
      pick = key_idx;
      kind = dlst_pkg::PICK_KEY;
    end else if (found_exp) begin
      pick = exp_idx;
      kind = dlst_pkg::PICK_EXPIRED;
    end else begin
      pick = '0;
      kind = dlst_pkg::PICK_FORCED;
    end
  end

  // multiplier operand select
  always_comb begin
    if (state == S_TMUL2) begin
      mul_a = {1'b0, prod[25:0], 5'b0};
      mul_b = dlst_pkg::RECIP;
    end else begin
      mul_a = {16'd0, fms_q};
      mul_b = {16'd0, entry.decay};
    end
  end
  assign mul_p = mul_a * mul_b;

  // memory port control
  always_comb begin
    rd_en   = (state == S_SCAN) || (state == S_TRD);
    rd_addr = idx;
    clr_all = accept && (action == dlst_pkg::ACT_CLEAR);
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = entry;
    case (state)
      S_AWRITE: begin
        wr_en   = 1'b1;
        wr_addr = pick;
        wr_data = '{key: key_q, expiry: nexp_q, radius: nrad_q, decay: ndec_q};
      end
      S_TWR: begin
        wr_en          = (entry.radius != 24'd0);
        wr_data.radius = rad_new;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata  <= mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      eval_on       <= 1'b0;
      result_strobe <= 1'b0;
      last_item     <= 1'b0;
      idx           <= '0;
    end else begin
      eval_on       <= rd_en;
      // emit strobes on each fresh read, allocate strobes once on its write
      result_strobe <= (eval_on && (act == dlst_pkg::ACT_EMIT)) || (state == S_AWRITE);
      last_item     <= (eval_on && (act == dlst_pkg::ACT_EMIT) && (rd_idx == LAST)) ||
                       (state == S_AWRITE);

      // allocate search and emit reporting on fresh read data
      if (eval_on && (act == dlst_pkg::ACT_ALLOC)) begin
        if (key_hit && !found_key) begin
          found_key <= 1'b1;
          key_idx   <= rd_idx;
        end
        if (expired && !found_exp) begin
          found_exp <= 1'b1;
          exp_idx   <= rd_idx;
        end
      end
      if (eval_on && (act == dlst_pkg::ACT_EMIT)) begin
        slot_index    <= 8'(rd_idx);
        slot_radius   <= entry.radius;
        slot_live     <= (entry.radius != 24'd0);
        pick_kind     <= dlst_pkg::PICK_KEY;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            act       <= dlst_pkg::action_t'(action);
            key_q     <= light_key;
            now_q     <= now_time;
            fms_q     <= frame_ms;
            nrad_q    <= new_radius;
            ndec_q    <= new_decay;
            nexp_q    <= new_expiry;
            found_key <= 1'b0;
            found_exp <= 1'b0;
            idx       <= '0;
            case (action)
              dlst_pkg::ACT_ALLOC: state <= S_SCAN;
              dlst_pkg::ACT_EMIT:  state <= S_SCAN;
              dlst_pkg::ACT_TICK:  state <= S_TRD;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (idx == LAST) begin
            state <= S_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TAIL: begin
          state <= (act == dlst_pkg::ACT_ALLOC) ? S_AWRITE : S_IDLE;
        end
        S_AWRITE: begin
          slot_index    <= 8'(pick);
          slot_radius   <= nrad_q;
          slot_live     <= (nrad_q != 24'd0);
          pick_kind     <= kind;
          state         <= S_IDLE;
        end
        S_TRD: begin
          state <= S_TMUL1;
        end
        S_TMUL1: begin
          prod  <= mul_p;
          state <= S_TMUL2;
        end
        S_TMUL2: begin
          big   <= (prod[31:0] >= dlst_pkg::DROP_LIMIT);
          prod  <= mul_p;
          state <= S_TWR;
        end
        S_TWR: begin
          if (idx == LAST) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_TRD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // results only come out of work in progress
  a_strobe_from_work: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(busy))
    else $error("result strobe without work in progress");

  // emit results arrive back to back in index order
  a_emit_order: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_item) |=>
      (result_strobe && (slot_index == $past(slot_index) + 8'd1)))
    else $error("emit results out of order or gapped");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    last_item |-> result_strobe)
    else $error("last_item without result strobe");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == dlst_pkg::ACT_TICK)) |=> busy)
    else $error("tick transfer did not start work");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (action == dlst_pkg::ACT_CLEAR)) |=> (!busy && !result_strobe))
    else $error("clear did not finish in one cycle");
`endif

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: decaying light slot table
// Walks a short table of directed commands, then random command streams
// under three sender pacing phases. Every transfer is run through a local
// copy of the slot table, and each result strobe is compared field by field
// with the oldest predicted report.
// ----------------------------------------------------------------------------
module testbench;

  localparam int NUM_SLOTS = dlst_pkg::SLOTS_DEF;
  // emit reports carry kind zero
  localparam logic [1:0] EMIT_KIND = dlst_pkg::PICK_KEY;
  // longest silent item is a tick, which visits every slot
  localparam int SETTLE_CYCLES = 4 * NUM_SLOTS + 16;
  localparam int DRAIN_LIMIT = 4000;
  localparam int PRINT_CAP = 100;

  // one predicted result strobe
  typedef struct packed {
    logic [7:0]  index;
    logic [23:0] radius;
    logic [1:0]  kind;
    logic        live;
    logic        last;
  } slot_report_t;

  // one directed command; typed rows carry their expected report by hand
  typedef struct {
    dlst_pkg::action_t act;
    logic [15:0] key;
    logic [30:0] now;
    logic [15:0] fms;
    logic [23:0] rad;
    logic [15:0] dec;
    logic [30:0] exp;
    bit          typed;
    logic [7:0]  tidx;
    logic [1:0]  tkind;
  } stim_row_t;

  // DUT inputs, all known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = dlst_pkg::ACT_EMIT;
  logic [15:0] light_key = '0;
  logic [30:0] now_time = '0;
  logic [15:0] frame_ms = '0;
  logic [23:0] new_radius = '0;
  logic [15:0] new_decay = '0;
  logic [30:0] new_expiry = '0;

  // DUT outputs
  logic        busy;
  logic        result_strobe;
  logic [7:0]  slot_index;
  logic [23:0] slot_radius;
  logic [1:0]  pick_kind;
  logic        slot_live;
  logic        last_item;

  // side channel for directed rows, driven alongside the command fields
  bit          row_typed = 1'b0;
  logic [7:0]  row_tidx = '0;
  logic [1:0]  row_tkind = '0;

  // shadow copy of the slot table
  logic [15:0] tbl_key    [NUM_SLOTS];
  logic [30:0] tbl_expiry [NUM_SLOTS];
  logic [23:0] tbl_radius [NUM_SLOTS];
  logic [15:0] tbl_decay  [NUM_SLOTS];

  slot_report_t pending_reports[$];
  int           err_count = 0;
  logic [30:0]  sim_ms;

  decaying_light_slot_table #(.SLOTS(NUM_SLOTS)) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .light_key    (light_key),
    .now_time     (now_time),
    .frame_ms     (frame_ms),
    .new_radius   (new_radius),
    .new_decay    (new_decay),
    .new_expiry   (new_expiry),
    .result_strobe(result_strobe),
    .slot_index   (slot_index),
    .slot_radius  (slot_radius),
    .pick_kind    (pick_kind),
    .slot_live    (slot_live),
    .last_item    (last_item)
  );

  always #1 clk = ~clk;

  // Run time cap, several times the slowest legal run.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic wipe_table();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_key[i] = '0;
      tbl_expiry[i] = '0;
      tbl_radius[i] = '0;
      tbl_decay[i] = '0;
    end
  endtask

  initial wipe_table();

  // Apply one accepted command to the shadow table and queue its reports.
  // On typed rows the hand-written report replaces the computed one.
  task automatic apply_to_table(input dlst_pkg::action_t act, input logic [15:0] key,
                                input logic [30:0] now, input logic [15:0] fms,
                                input logic [23:0] rad, input logic [15:0] dec,
                                input logic [30:0] exp, input bit typed,
                                input logic [7:0] tidx, input logic [1:0] tkind);
    int          pick;
    logic [1:0]  kind;
    logic [63:0] drop;
    logic [23:0] r;
    case (act)
      dlst_pkg::ACT_ALLOC: begin
        pick = -1;
        kind = dlst_pkg::PICK_FORCED;
        // a zero key never matches, even against empty slots
        if (key != 16'd0) begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (pick < 0 && tbl_key[i] == key) begin
              pick = i;
              kind = dlst_pkg::PICK_KEY;
            end
        end
        // expiry must be strictly below now
        if (pick < 0) begin
          for (int i = 0; i < NUM_SLOTS; i++)
            if (pick < 0 && tbl_expiry[i] < now) begin
              pick = i;
              kind = dlst_pkg::PICK_EXPIRED;
            end
        end
        if (pick < 0) pick = 0;
        tbl_key[pick] = key;
        tbl_radius[pick] = rad;
        tbl_decay[pick] = dec;
        tbl_expiry[pick] = exp;
        if (typed)
          pending_reports.push_back({tidx, rad, tkind, rad != 24'd0, 1'b1});
        else
          pending_reports.push_back({8'(pick), rad, kind, rad != 24'd0, 1'b1});
      end
      dlst_pkg::ACT_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tbl_radius[i] != 24'd0) begin
            if (tbl_expiry[i] < now) begin
              tbl_radius[i] = '0;
            end else begin
              // 16.8 drop, truncated toward zero, saturating at empty
              drop = (64'(fms) * 64'(tbl_decay[i]) * 64'd256) / 64'd1000;
              if (drop >= 64'(tbl_radius[i])) tbl_radius[i] = '0;
              else tbl_radius[i] = tbl_radius[i] - drop[23:0];
            end
          end
        end
      end
      dlst_pkg::ACT_EMIT: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          r = typed ? 24'd0 : tbl_radius[i];
          pending_reports.push_back({8'(i), r, EMIT_KIND, r != 24'd0,
                                     i == NUM_SLOTS - 1});
        end
      end
      default: wipe_table();
    endcase
  endtask

  // Monitor: sampled at the rising edge, before the DUT's updates land.
  // Result strobes are checked first, then a transfer (start && !busy)
  // feeds the shadow table.
  always @(posedge clk) begin : monitor
    slot_report_t want;
    if (!rst) begin
      if (result_strobe) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: index %0d radius %h",
                                    slot_index, slot_radius));
        end else begin
          want = pending_reports.pop_front();
          if (slot_index !== want.index || slot_radius !== want.radius ||
              pick_kind !== want.kind || slot_live !== want.live ||
              last_item !== want.last)
            report_mismatch($sformatf(
              "got/want index %0d/%0d radius %h/%h kind %0d/%0d live %b/%b last %b/%b",
              slot_index, want.index, slot_radius, want.radius, pick_kind, want.kind,
              slot_live, want.live, last_item, want.last));
        end
      end
      if (start && !busy)
        apply_to_table(dlst_pkg::action_t'(action), light_key, now_time, frame_ms,
                       new_radius, new_decay, new_expiry, row_typed, row_tidx, row_tkind);
    end
  end

  // Present one command and hold it until the transfer edge. Returns at
  // that edge with start still high, so the caller either follows with
  // the next command or drops start, never both in one step.
  task automatic send(input dlst_pkg::action_t act, input logic [15:0] key,
                      input logic [30:0] now, input logic [15:0] fms,
                      input logic [23:0] rad, input logic [15:0] dec,
                      input logic [30:0] exp, input bit typed,
                      input logic [7:0] tidx, input logic [1:0] tkind);
    action <= act;
    light_key <= key;
    now_time <= now;
    frame_ms <= fms;
    new_radius <= rad;
    new_decay <= dec;
    new_expiry <= exp;
    row_typed <= typed;
    row_tidx <= tidx;
    row_tkind <= tkind;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every predicted report has come, then let a silent
  // tick run out before anything else is sent.
  task automatic wait_drained();
    start <= 1'b0;
    for (int w = 0; w < DRAIN_LIMIT && pending_reports.size() != 0; w++)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Random command. sim_ms is a running clock so that most allocations
  // and ticks see sensible expiries; a share of fields is fully random.
  task automatic send_random();
    int          sel;
    dlst_pkg::action_t act;
    logic [15:0] key;
    logic [15:0] fms;
    logic [15:0] dec;
    logic [30:0] now;
    logic [30:0] exp;
    logic [23:0] rad;
    sel = $urandom_range(0, 99);
    if (sel < 60) act = dlst_pkg::ACT_ALLOC;
    else if (sel < 82) act = dlst_pkg::ACT_TICK;
    else if (sel < 98) act = dlst_pkg::ACT_EMIT;
    else act = dlst_pkg::ACT_CLEAR;

    sel = $urandom_range(0, 9);
    if (sel == 0) key = '0;
    else if (sel < 7) key = 16'($urandom_range(1, 40));
    else key = 16'($urandom);

    sel = $urandom_range(0, 9);
    if (sel < 8) fms = 16'($urandom_range(0, 100));
    else fms = 16'($urandom);

    if (act == dlst_pkg::ACT_TICK) sim_ms = sim_ms + 31'(fms);
    if ($urandom_range(0, 99) < 85) now = sim_ms;
    else now = 31'($urandom);

    if ($urandom_range(0, 1) == 0) rad = 24'($urandom);
    else rad = 24'($urandom_range(0, 24'h004000));

    sel = $urandom_range(0, 9);
    if (sel < 6) dec = 16'($urandom_range(0, 2000));
    else if (sel < 9) dec = 16'($urandom);
    else dec = '0;

    sel = $urandom_range(0, 9);
    if (sel < 7) exp = sim_ms + 31'($urandom_range(0, 3000));
    else if (sel < 9) exp = 31'($urandom);
    else exp = ($urandom_range(0, 1) == 0) ? 31'd0 : 31'h7FFF_FFFF;

    send(act, key, now, fms, rad, dec, exp, 1'b0, '0, '0);
  endtask

  // Directed table. Typed rows: emits of an empty table and allocations
  // whose pick follows at a glance. The rest go through the shadow table.
  stim_row_t directed_rows [23] = '{
    // empty table after reset
    '{dlst_pkg::ACT_EMIT,  16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b1, 8'd0, dlst_pkg::PICK_KEY},
    // nothing below now zero: forced slot zero, widest radius and expiry
    '{dlst_pkg::ACT_ALLOC, 16'h0000, 31'h0000_0000, 16'h0000, 24'hFFFFFF, 16'h0000,
      31'h7FFF_FFFF, 1'b1, 8'd0, dlst_pkg::PICK_FORCED},
    // no key match, slot one has expiry zero below now
    '{dlst_pkg::ACT_ALLOC, 16'h1234, 31'h0000_0001, 16'h0000, 24'h000100, 16'h0001,
      31'h0000_000A, 1'b1, 8'd1, dlst_pkg::PICK_EXPIRED},
    // same key again takes its own slot back
    '{dlst_pkg::ACT_ALLOC, 16'h1234, 31'h0000_0001, 16'h0000, 24'h000100, 16'h0001,
      31'h0000_000A, 1'b1, 8'd1, dlst_pkg::PICK_KEY},
    // zero radius load, reported not live
    '{dlst_pkg::ACT_ALLOC, 16'hFFFF, 31'h0000_0005, 16'h0000, 24'h000000, 16'hFFFF,
      31'h0000_0000, 1'b1, 8'd2, dlst_pkg::PICK_EXPIRED},
    // zero key with key-zero slots around still falls through to forced
    '{dlst_pkg::ACT_ALLOC, 16'h0000, 31'h0000_0000, 16'h0000, 24'h001000, 16'hFFFF,
      31'h0000_0064, 1'b1, 8'd0, dlst_pkg::PICK_FORCED},
    // expiry equal to now is not expired; drop equal to radius empties it,
    // huge drop saturates at zero
    '{dlst_pkg::ACT_TICK,  16'h0000, 31'h0000_000A, 16'd1000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_EMIT,  16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_ALLOC, 16'h8000, 31'h0000_0000, 16'h0000, 24'h7FFFFF, 16'h0001,
      31'h0000_0014, 1'b1, 8'd0, dlst_pkg::PICK_FORCED},
    '{dlst_pkg::ACT_ALLOC, 16'h0001, 31'h0000_000B, 16'h0000, 24'hABCDEF, 16'h0003,
      31'h0000_001E, 1'b1, 8'd1, dlst_pkg::PICK_EXPIRED},
    // sub-unit drop truncates to nothing
    '{dlst_pkg::ACT_TICK,  16'h0000, 31'h0000_0014, 16'h0001, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    // expired slot loses its radius even with zero frame time
    '{dlst_pkg::ACT_TICK,  16'h0000, 31'h0000_0015, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_EMIT,  16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    // key match wins over an earlier expired slot
    '{dlst_pkg::ACT_ALLOC, 16'h0001, 31'h7FFF_FFFF, 16'h0000, 24'h000001, 16'hFFFF,
      31'h7FFF_FFFF, 1'b1, 8'd1, dlst_pkg::PICK_KEY},
    // widest frame time and decay
    '{dlst_pkg::ACT_TICK,  16'h0000, 31'h7FFF_FFFF, 16'hFFFF, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_EMIT,  16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_CLEAR, 16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_EMIT,  16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b1, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_ALLOC, 16'h0000, 31'h7FFF_FFFF, 16'h0000, 24'h555555, 16'hAAAA,
      31'h2AAA_AAAA, 1'b1, 8'd0, dlst_pkg::PICK_EXPIRED},
    '{dlst_pkg::ACT_ALLOC, 16'h5555, 31'h2AAA_AAAB, 16'h5555, 24'hAAAAAA, 16'h5555,
      31'h5555_5555, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_TICK,  16'hAAAA, 31'h0000_0000, 16'hAAAA, 24'h555555, 16'hAAAA,
      31'h2AAA_AAAA, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_EMIT,  16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY},
    '{dlst_pkg::ACT_CLEAR, 16'h0000, 31'h0000_0000, 16'h0000, 24'h000000, 16'h0000,
      31'h0000_0000, 1'b0, 8'd0, dlst_pkg::PICK_KEY}
  };

  // Sender idle share per random phase; the receiver cannot stall, so
  // pacing only varies on the command side.
  int idle_pct [3] = '{0, 71, 18};

  initial begin : stimulus
    stim_row_t row;
    sim_ms = 31'($urandom_range(1000, 100000));
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      send(row.act, row.key, row.now, row.fms, row.rad, row.dec, row.exp,
           row.typed, row.tidx, row.tkind);
    end
    wait_drained();

    // each phase ends with a full drain before the next begins
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < 129; n++) begin
        if ($urandom_range(0, 99) < idle_pct[ph]) idle_for($urandom_range(1, 40));
        send_random();
      end
      wait_drained();
    end

    if (pending_reports.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                pending_reports.size()));
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/dlst_pkg.sv
src/decaying_light_slot_table.sv
tb/sv/testbench.sv
